@@ src/utf8f_pkg.sv @@
// Shared types and constants for the UTF-8 decoder with punctuation folding.
// No dependencies; used by utf8f_decode and utf8_decoder_with_fold_top.
`default_nettype none

package utf8f_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned CNT_W    = 3;   // result count per item, 0..4
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register word index (paddr[2])
  localparam logic REG_FOLD = 1'b0;

  localparam logic [BYTE_W-1:0] ASCII_LIM = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF4;

  localparam logic [CP_W-1:0] QMARK      = 21'h00003F;
  localparam logic [CP_W-1:0] CP_EN_DASH = 21'h002013;
  localparam logic [CP_W-1:0] CP_EM_DASH = 21'h002014;
  localparam logic [CP_W-1:0] CP_LSQUO   = 21'h002018;
  localparam logic [CP_W-1:0] CP_RSQUO   = 21'h002019;
  localparam logic [CP_W-1:0] CP_LDQUO   = 21'h00201C;
  localparam logic [CP_W-1:0] CP_RDQUO   = 21'h00201D;
  localparam logic [CP_W-1:0] CP_HYPHEN  = 21'h00002D;
  localparam logic [CP_W-1:0] CP_APOS    = 21'h000027;
  localparam logic [CP_W-1:0] CP_QUOTE   = 21'h000022;

  // Open-sequence state carried between items
  typedef struct packed {
    logic [1:0]      br;   // continuations still expected
    logic [1:0]      gc;   // continuations already taken
    logic [CP_W-1:0] pp;   // code point bits gathered so far
  } seq_state_t;

  localparam seq_state_t SEQ_IDLE = '{br: 2'd0, gc: 2'd0, pp: '0};

  // Results of one item: cnt results, all '?' except the final one,
  // which carries cp/sub. last marks the final byte of the string.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
    logic             sub;
    logic             last;
  } burst_t;

endpackage

`default_nettype wire

@@ src/utf8f_decode.sv @@
// Single-pass decode of one byte against the open-sequence state.
// Depends on utf8f_pkg for state and result types.
`default_nettype none

module utf8f_decode (
  input  wire logic [utf8f_pkg::BYTE_W-1:0] text_byte,
  input  wire logic                         string_last,
  input  wire logic                         fold_en,
  input  wire utf8f_pkg::seq_state_t        cur,
  output utf8f_pkg::seq_state_t             nxt,
  output utf8f_pkg::burst_t                 res
);

  logic                         cont;
  logic [utf8f_pkg::CP_W-1:0]   pp_ext;
  logic [utf8f_pkg::CNT_W-1:0]  flush;
  logic [utf8f_pkg::CNT_W-1:0]  open_q;

  function automatic logic [utf8f_pkg::CP_W-1:0] fold_cp(
    input logic                       en,
    input logic [utf8f_pkg::CP_W-1:0] cp
  );
    logic [utf8f_pkg::CP_W-1:0] r;
    r = cp;
    if (en) begin
      if (cp == utf8f_pkg::CP_EN_DASH || cp == utf8f_pkg::CP_EM_DASH) begin
        r = utf8f_pkg::CP_HYPHEN;
      end else if (cp == utf8f_pkg::CP_LSQUO || cp == utf8f_pkg::CP_RSQUO) begin
        r = utf8f_pkg::CP_APOS;
      end else if (cp == utf8f_pkg::CP_LDQUO || cp == utf8f_pkg::CP_RDQUO) begin
        r = utf8f_pkg::CP_QUOTE;
      end
    end
    return r;
  endfunction

  assign cont   = (text_byte[7:6] == 2'b10);
  assign pp_ext = {cur.pp[14:0], text_byte[5:0]};
  // a lead that opens a sequence on the final byte flushes straight away
  assign open_q = string_last ? 3'd1 : 3'd0;

  always_comb begin
    nxt      = cur;
    flush    = '0;
    res.cnt  = '0;
    res.cp   = utf8f_pkg::QMARK;
    res.sub  = 1'b1;
    res.last = string_last;
    if (cur.br != 2'd0 && cont) begin
      nxt.pp = pp_ext;
      nxt.gc = cur.gc + 2'd1;
      nxt.br = cur.br - 2'd1;
      if (cur.br == 2'd1) begin
        res.cnt = 3'd1;
        res.cp  = fold_cp(fold_en, pp_ext);
        res.sub = 1'b0;
        nxt     = utf8f_pkg::SEQ_IDLE;
      end else if (string_last) begin
        res.cnt = 3'd1 + {1'b0, nxt.gc};
      end
    end else begin
      if (cur.br != 2'd0) begin
        flush = 3'd1 + {1'b0, cur.gc};
      end
      nxt = utf8f_pkg::SEQ_IDLE;
      if (text_byte < utf8f_pkg::ASCII_LIM) begin
        res.cnt = flush + 3'd1;
        res.cp  = {13'd0, text_byte};
        res.sub = 1'b0;
      end else if (text_byte >= utf8f_pkg::LEAD2_LO && text_byte <= utf8f_pkg::LEAD2_HI) begin
        nxt.br  = 2'd1;
        nxt.pp  = {16'd0, text_byte[4:0]};
        res.cnt = flush + open_q;
      end else if (text_byte >= utf8f_pkg::LEAD3_LO && text_byte <= utf8f_pkg::LEAD3_HI) begin
        nxt.br  = 2'd2;
        nxt.pp  = {17'd0, text_byte[3:0]};
        res.cnt = flush + open_q;
      end else if (text_byte >= utf8f_pkg::LEAD4_LO && text_byte <= utf8f_pkg::LEAD4_HI) begin
        nxt.br  = 2'd3;
        nxt.pp  = {18'd0, text_byte[2:0]};
        res.cnt = flush + open_q;
      end else begin
        res.cnt = flush + 3'd1;
      end
    end
    if (string_last) begin
      nxt = utf8f_pkg::SEQ_IDLE;
    end
  end

endmodule

`default_nettype wire

@@ src/utf8_decoder_with_fold_top.sv @@
// Top level of the UTF-8 decoder with punctuation folding: handshakes,
// config register, result burst register and skid slot. Uses utf8f_pkg, utf8f_decode.
`default_nettype none

// Takes one UTF-8 byte per item (text_byte, string_last marking the final
// byte of a string) and returns zero to four code point results per item.
// A byte is accepted in any cycle in which in_ready is high; in_ready is a
// register output and falls only while the one-entry skid slot is full.
// Decoding is done in the accept cycle by a short combinational pass over
// the byte and the open-sequence state, and the item's results go to a
// burst register that hands them out one per cycle while out_ready is high;
// an item with several results holds the output until its final result is
// taken. Plain text runs at one byte per cycle while out_ready is high, and
// only the rare bursts after bad input (up to four replacement '?' results)
// hold the input back. Bytes that only open or extend a sequence yield no result.
// Folding of dashes and curly quotes is set by fold_punctuation (bit 0 of
// the register at byte address 0, reset 1); write it only while idle.
module utf8_decoder_with_fold_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // byte input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [utf8f_pkg::BYTE_W-1:0]        text_byte,
  input  wire logic                                string_last,
  // result output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [utf8f_pkg::CP_W-1:0]               code_point,
  output logic                                     substituted,
  output logic                                     run_last,
  output logic                                     string_end,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [utf8f_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [utf8f_pkg::PDATA_W-1:0]       pwdata,
  output logic [utf8f_pkg::PDATA_W-1:0]            prdata,
  output logic                                     pready
);

  logic                        fold_punctuation;
  utf8f_pkg::seq_state_t       seq;
  utf8f_pkg::seq_state_t       seq_next;
  utf8f_pkg::burst_t           dec;

  // burst register and skid slot
  logic                        b_valid;
  utf8f_pkg::burst_t           burst;
  logic [utf8f_pkg::CNT_W-1:0] rem;
  logic                        skid_valid;
  utf8f_pkg::burst_t           skid;

  logic                        acc;
  logic                        has_res;
  logic                        out_hs;
  logic                        fin;
  logic                        b_free;
  logic                        final_one;

  utf8f_decode u_decode (
    .text_byte   (text_byte),
    .string_last (string_last),
    .fold_en     (fold_punctuation),
    .cur         (seq),
    .nxt         (seq_next),
    .res         (dec)
  );

  assign in_ready  = !skid_valid;
  assign acc       = in_valid && in_ready;
  assign has_res   = (dec.cnt != '0);
  assign out_valid = b_valid;
  assign out_hs    = out_valid && out_ready;
  assign final_one = (rem == 3'd1);
  assign fin       = out_hs && final_one;
  assign b_free    = !b_valid || fin;

  // every result before the final one of an item is a replacement '?'
  assign code_point  = final_one ? burst.cp : utf8f_pkg::QMARK;
  assign substituted = final_one ? burst.sub : 1'b1;
  assign run_last    = final_one;
  assign string_end  = final_one && burst.last;

  // configuration port: writes land on the access phase, no wait states
  assign pready = 1'b1;
  assign prdata = {{(utf8f_pkg::PDATA_W-1){1'b0}}, fold_punctuation};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_punctuation <= 1'b1;
      seq              <= utf8f_pkg::SEQ_IDLE;
      b_valid          <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == utf8f_pkg::REG_FOLD) begin
        fold_punctuation <= pwdata[0];
      end
      if (acc) begin
        seq <= seq_next;
      end
      // burst register: refill from the skid slot first, else from the input
      if (fin) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!(acc && has_res)) begin
          b_valid <= 1'b0;
        end
      end else if (!b_valid && acc && has_res) begin
        b_valid <= 1'b1;
      end
      // park the item while the burst register is still busy
      if (acc && has_res && !b_free) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload: burst contents, countdown of results left, skid contents
  always_ff @(posedge clk) begin
    if (fin && skid_valid) begin
      burst <= skid;
      rem   <= skid.cnt;
    end else if (b_free && acc && has_res) begin
      burst <= dec;
      rem   <= dec.cnt;
    end else if (out_hs) begin
      rem   <= rem - 3'd1;
    end
    if (acc && has_res && !b_free) begin
      skid <= dec;
    end
  end

  // the skid slot only fills behind a busy burst register
  a_skid_behind_burst: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> b_valid)
    else $error("skid slot holds an item with no burst in progress");

  // a burst that is not finished keeps presenting results
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_hs && !final_one) |=> out_valid)
    else $error("burst dropped before its final result");

  // only the final result of an item may carry a real code point
  a_early_are_qmarks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_last) |-> (substituted && code_point == utf8f_pkg::QMARK))
    else $error("non-final result is not a replacement");

  // countdown stays within one item's result count
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rem != 3'd0 && rem <= burst.cnt && burst.cnt <= 3'd4))
    else $error("result countdown out of range");

endmodule

`default_nettype wire
